// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file clx_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/clx_pkg.sv =====
// types, codes and character classes for the c-like lexer
// no dependencies
`default_nettype none

package clx_pkg;

	// payload of one source byte transfer
	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_text;
	} char_item_t;

	// payload of one token byte transfer
	typedef struct packed {
		logic [2:0]  token_class;
		logic [5:0]  operator_code;
		logic [7:0]  value_byte;
		logic        value_valid;
		logic [15:0] line_number;
		logic        last_of_token;
	} token_item_t;

	// token byte slots per source byte; one source byte causes at most three
	localparam int MAX_RES = 4;

	// token classes
	localparam logic [2:0] C_IDENT  = 3'd0;
	localparam logic [2:0] C_STRING = 3'd1;
	localparam logic [2:0] C_DEC    = 3'd2;
	localparam logic [2:0] C_HEX    = 3'd3;
	localparam logic [2:0] C_OP     = 3'd4;

	// operator codes
	localparam logic [5:0] OP_NONE = 6'd0,  OP_EQEQ = 6'd1,  OP_EQ = 6'd2,    OP_SCOPE = 6'd3;
	localparam logic [5:0] OP_LABEL = 6'd4, OP_INC = 6'd5,   OP_ADDEQ = 6'd6, OP_ADD = 6'd7;
	localparam logic [5:0] OP_DEC = 6'd8,   OP_SUBEQ = 6'd9, OP_ARROW = 6'd10, OP_SUB = 6'd11;
	localparam logic [5:0] OP_MULEQ = 6'd12, OP_MUL = 6'd13, OP_DIVEQ = 6'd14, OP_DIV = 6'd15;
	localparam logic [5:0] OP_LAND = 6'd16, OP_ANDEQ = 6'd17, OP_AND = 6'd18, OP_LOR = 6'd19;
	localparam logic [5:0] OP_OREQ = 6'd20, OP_OR = 6'd21,   OP_XOREQ = 6'd22, OP_XOR = 6'd23;
	localparam logic [5:0] OP_SHREQ = 6'd24, OP_SHR = 6'd25, OP_GE = 6'd26,   OP_GT = 6'd27;
	localparam logic [5:0] OP_SHLEQ = 6'd28, OP_SHL = 6'd29, OP_LE = 6'd30,   OP_LT = 6'd31;
	localparam logic [5:0] OP_MODEQ = 6'd32, OP_MOD = 6'd33, OP_NE = 6'd34,   OP_NOT = 6'd35;
	localparam logic [5:0] OP_TILDE = 6'd36, OP_SEPARATOR = 6'd37, OP_DOTSTAR = 6'd38;
	localparam logic [5:0] OP_DOT = 6'd39,  OP_LPAREN = 6'd40, OP_RPAREN = 6'd41;
	localparam logic [5:0] OP_LBRACK = 6'd42, OP_RBRACK = 6'd43, OP_LBRACE = 6'd44;
	localparam logic [5:0] OP_RBRACE = 6'd45, OP_SEMI = 6'd46, OP_HASH = 6'd47;

	// character constants
	localparam logic [7:0] CH_SLASH = 8'h2f, CH_STAR = 8'h2a, CH_UNDER = 8'h5f;
	localparam logic [7:0] CH_QUOTE = 8'h22, CH_ZERO = 8'h30, CH_X = 8'h78, CH_NL = 8'h0a;
	localparam logic [7:0] CH_EQ = 8'h3d, CH_GT = 8'h3e, CH_LT = 8'h3c;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_xdigit(input logic [7:0] c);
		return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || c == CH_UNDER;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == " " || c == 8'h09 || c == 8'h0b || c == 8'h0c || c == 8'h0d;
	endfunction

	// code of a one-character operator
	function automatic logic [5:0] single_code(input logic [7:0] c);
		logic [5:0] r;
		unique case (c)
			"=": r = OP_EQ;     ":": r = OP_LABEL;  "+": r = OP_ADD;    "-": r = OP_SUB;
			"*": r = OP_MUL;    "/": r = OP_DIV;    "&": r = OP_AND;    "|": r = OP_OR;
			"^": r = OP_XOR;    ">": r = OP_GT;     "<": r = OP_LT;     "%": r = OP_MOD;
			"!": r = OP_NOT;    "~": r = OP_TILDE;  ",": r = OP_SEPARATOR; ".": r = OP_DOT;
			"(": r = OP_LPAREN; ")": r = OP_RPAREN; "[": r = OP_LBRACK; "]": r = OP_RBRACK;
			"{": r = OP_LBRACE; "}": r = OP_RBRACE; ";": r = OP_SEMI;   "#": r = OP_HASH;
			default: r = OP_NONE;
		endcase
		return r;
	endfunction

	// bytes that may open a two-character operator
	function automatic logic starts_pair(input logic [7:0] c);
		return c == "=" || c == ":" || c == "+" || c == "-" || c == "*" || c == "/" ||
			c == "&" || c == "|" || c == "^" || c == ">" || c == "<" || c == "%" ||
			c == "!" || c == ".";
	endfunction

	// code of a two-character operator, none if the pair is no operator or is a shift (>> or <<)
	function automatic logic [5:0] pair_code(input logic [7:0] a, input logic [7:0] b);
		logic [5:0] r;
		r = OP_NONE;
		if (b == CH_EQ) begin
			unique case (a)
				"=": r = OP_EQEQ;  "+": r = OP_ADDEQ; "-": r = OP_SUBEQ; "*": r = OP_MULEQ;
				"/": r = OP_DIVEQ; "&": r = OP_ANDEQ; "|": r = OP_OREQ;  "^": r = OP_XOREQ;
				">": r = OP_GE;    "<": r = OP_LE;    "%": r = OP_MODEQ; "!": r = OP_NE;
				default: r = OP_NONE;
			endcase
		end else if (a == ":" && b == ":") r = OP_SCOPE;
		else if (a == "+" && b == "+") r = OP_INC;
		else if (a == "-" && b == "-") r = OP_DEC;
		else if (a == "-" && b == ">") r = OP_ARROW;
		else if (a == "&" && b == "&") r = OP_LAND;
		else if (a == "|" && b == "|") r = OP_LOR;
		else if (a == "." && b == "*") r = OP_DOTSTAR;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/clx_core.sv =====
// lexer state and the token bytes caused by one source byte
// depends on clx_pkg
`default_nettype none

module clx_core
	import clx_pkg::*;
#(
	parameter int LINE_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        fire,
	input  wire char_item_t  item,
	output token_item_t      res [MAX_RES],
	output logic [2:0]       res_count
);

	typedef enum logic [3:0] {
		M_IDLE, M_IDENT, M_STRING, M_ZERO, M_DECIMAL, M_HEX,
		M_OP1, M_OP2, M_LCOMMENT, M_BLOCK, M_BLOCK_STAR
	} mode_t;

	localparam logic [LINE_WIDTH-1:0] LINE_TOP = {LINE_WIDTH{1'b1}};
	localparam logic [LINE_WIDTH-1:0] LINE_ONE = LINE_WIDTH'(1);

	mode_t                 mode_q, mode_d;
	logic [7:0]            pend_q, pend_d;
	logic                  have_q, have_d;
	logic [LINE_WIDTH-1:0] line_q, line_d, tline_q, tline_d;

	// widen or truncate a line count to the 16-bit port field
	function automatic logic [15:0] line16(input logic [LINE_WIDTH-1:0] l);
		logic [LINE_WIDTH+15:0] e;
		e = {16'b0, l};
		return e[15:0];
	endfunction

	function automatic token_item_t mk(input logic [2:0] cls, input logic [5:0] code,
			input logic [7:0] b, input logic v, input logic last,
			input logic [LINE_WIDTH-1:0] l);
		token_item_t t;
		t.token_class   = cls;
		t.operator_code = code;
		t.value_byte    = v ? b : 8'd0;
		t.value_valid   = v;
		t.line_number   = line16(l);
		t.last_of_token = last;
		return t;
	endfunction

	// next state and emitted bytes
	always_comb begin
		logic [7:0]            b;
		logic [7:0]            a;
		logic                  do_flush;
		logic                  do_idle;
		logic [5:0]            pc;
		logic [5:0]            c2;
		logic [2:0]            sh_cls;
		logic                  do_shift;
		logic [LINE_WIDTH-1:0] line_inc;
		b        = item.char_byte;
		a        = pend_q;
		mode_d   = mode_q;
		pend_d   = pend_q;
		have_d   = have_q;
		line_d   = line_q;
		tline_d  = tline_q;
		res_count = 3'd0;
		for (int i = 0; i < MAX_RES; i++) res[i] = '0;
		do_flush = 1'b0;
		do_idle  = 1'b0;
		do_shift = 1'b0;
		sh_cls   = C_IDENT;
		pc       = pair_code(a, b);
		c2       = OP_NONE;
		line_inc = (line_q == LINE_TOP) ? line_q : line_q + LINE_ONE;

		if (item.end_of_text) begin
			do_flush = 1'b1;
		end else begin
			unique case (mode_q)
				M_IDENT: begin
					if (is_word(b)) begin
						do_shift = 1'b1; sh_cls = C_IDENT;
					end else begin
						do_flush = 1'b1; do_idle = 1'b1;
					end
				end
				M_DECIMAL: begin
					if (is_digit(b)) begin
						do_shift = 1'b1; sh_cls = C_DEC;
					end else begin
						do_flush = 1'b1; do_idle = 1'b1;
					end
				end
				M_ZERO: begin
					priority if (b == CH_X) begin
						mode_d = M_HEX; have_d = 1'b0;
					end else if (is_digit(b)) begin
						mode_d = M_DECIMAL; do_shift = 1'b1; sh_cls = C_DEC;
					end else begin
						do_flush = 1'b1; do_idle = 1'b1;
					end
				end
				M_HEX: begin
					if (is_xdigit(b)) begin
						do_shift = 1'b1; sh_cls = C_HEX;
					end else begin
						do_flush = 1'b1; do_idle = 1'b1;
					end
				end
				M_STRING: begin
					if (b == CH_QUOTE) begin
						do_flush = 1'b1;
					end else begin
						if (b == CH_NL) line_d = line_inc;
						do_shift = 1'b1; sh_cls = C_STRING;
					end
				end
				M_OP1: begin
					priority if (a == CH_SLASH && b == CH_SLASH) begin
						mode_d = M_LCOMMENT; have_d = 1'b0;
					end else if (a == CH_SLASH && b == CH_STAR) begin
						mode_d = M_BLOCK; have_d = 1'b0;
					end else if ((a == CH_GT || a == CH_LT) && b == a) begin
						mode_d = M_OP2; have_d = 1'b1;
					end else if (pc != OP_NONE) begin
						res[0] = mk(C_OP, pc, a, 1'b1, 1'b0, tline_q);
						res[1] = mk(C_OP, pc, b, 1'b1, 1'b1, tline_q);
						res_count = 3'd2;
						mode_d = M_IDLE; have_d = 1'b0;
					end else begin
						do_flush = 1'b1; do_idle = 1'b1;
					end
				end
				M_OP2: begin
					if (b == CH_EQ) begin
						c2 = (a == CH_GT) ? OP_SHREQ : OP_SHLEQ;
						res[0] = mk(C_OP, c2, a, 1'b1, 1'b0, tline_q);
						res[1] = mk(C_OP, c2, a, 1'b1, 1'b0, tline_q);
						res[2] = mk(C_OP, c2, b, 1'b1, 1'b1, tline_q);
						res_count = 3'd3;
						mode_d = M_IDLE; have_d = 1'b0;
					end else begin
						do_flush = 1'b1; do_idle = 1'b1;
					end
				end
				M_LCOMMENT: begin
					if (b == CH_NL) begin
						line_d = line_inc; mode_d = M_IDLE;
					end
				end
				M_BLOCK, M_BLOCK_STAR: begin
					priority if (b == CH_NL) begin
						line_d = line_inc; mode_d = M_BLOCK;
					end else if (mode_q == M_BLOCK_STAR && b == CH_SLASH) begin
						mode_d = M_IDLE;
					end else begin
						mode_d = (b == CH_STAR) ? M_BLOCK_STAR : M_BLOCK;
					end
				end
				default: begin
					do_flush = 1'b1; do_idle = 1'b1;
				end
			endcase
		end

		// held byte leaves as a non-final byte, new byte is held
		if (do_shift) begin
			if (have_q) begin
				res[0] = mk(sh_cls, OP_NONE, a, 1'b1, 1'b0, tline_q);
				res_count = 3'd1;
			end
			pend_d = b;
			have_d = 1'b1;
		end

		// close the pending token
		if (do_flush) begin
			unique case (mode_q)
				M_IDENT: begin
					res[0] = mk(C_IDENT, OP_NONE, a, 1'b1, 1'b1, tline_q);
					res_count = 3'd1;
				end
				M_DECIMAL, M_ZERO: begin
					res[0] = mk(C_DEC, OP_NONE, a, 1'b1, 1'b1, tline_q);
					res_count = 3'd1;
				end
				M_STRING: begin
					res[0] = mk(C_STRING, OP_NONE, a, have_q, 1'b1, tline_q);
					res_count = 3'd1;
				end
				M_HEX: begin
					res[0] = mk(C_HEX, OP_NONE, a, have_q, 1'b1, tline_q);
					res_count = 3'd1;
				end
				M_OP1: begin
					res[0] = mk(C_OP, single_code(a), a, 1'b1, 1'b1, tline_q);
					res_count = 3'd1;
				end
				M_OP2: begin
					c2 = (a == CH_GT) ? OP_SHR : OP_SHL;
					res[0] = mk(C_OP, c2, a, 1'b1, 1'b0, tline_q);
					res[1] = mk(C_OP, c2, a, 1'b1, 1'b1, tline_q);
					res_count = 3'd2;
				end
				default: res_count = 3'd0;
			endcase
			mode_d = M_IDLE;
			have_d = 1'b0;
		end

		// the new byte seen between tokens
		if (do_idle) begin
			priority if (b == CH_NL) begin
				line_d = line_inc;
			end else if (is_blank(b)) begin
				line_d = line_q;
			end else if (is_alpha(b) || b == CH_UNDER) begin
				mode_d = M_IDENT; pend_d = b; have_d = 1'b1; tline_d = line_q;
			end else if (b == CH_QUOTE) begin
				mode_d = M_STRING; pend_d = 8'd0; have_d = 1'b0; tline_d = line_q;
			end else if (b == CH_ZERO) begin
				mode_d = M_ZERO; pend_d = b; have_d = 1'b1; tline_d = line_q;
			end else if (is_digit(b)) begin
				mode_d = M_DECIMAL; pend_d = b; have_d = 1'b1; tline_d = line_q;
			end else if (starts_pair(b)) begin
				mode_d = M_OP1; pend_d = b; have_d = 1'b1; tline_d = line_q;
			end else begin
				tline_d = line_q;
				res[res_count[1:0]] = mk(C_OP, single_code(b), b, 1'b1, 1'b1, line_q);
				res_count = res_count + 3'd1;
			end
		end

		if (item.end_of_text) line_d = LINE_ONE;
	end

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			pend_q  <= 8'd0;
			have_q  <= 1'b0;
			line_q  <= LINE_ONE;
			tline_q <= LINE_ONE;
		end else if (fire) begin
			mode_q  <= mode_d;
			pend_q  <= pend_d;
			have_q  <= have_d;
			line_q  <= line_d;
			tline_q <= tline_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/c_like_lexer_unit.sv =====
// Streaming lexer for C-like text: one source byte per transfer in, one token byte
// per transfer out. A source byte is taken while the output queue has four free
// slots; the token bytes it causes (zero to three) go to an eight-entry queue in
// that same cycle and leave at one per cycle while tok_ready is high. Sustained
// rate is one source byte per cycle while the bytes produced average at most one
// per byte and tok_ready stays high; otherwise the queue drain sets the pace.
// The last byte of a token appears only after the byte that ends it arrives.
// depends on clx_pkg and clx_core
`default_nettype none

module c_like_lexer_unit
	import clx_pkg::*;
#(
	parameter int LINE_WIDTH = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  char_valid,
	output logic       char_ready,
	input  wire char_item_t char_item,
	output logic       tok_valid,
	input  wire logic  tok_ready,
	output token_item_t tok_item
);

	localparam int DEPTH = 8;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	token_item_t   res [MAX_RES];
	logic [2:0]    res_count;
	logic          fire, pop;
	token_item_t   fifo_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;

	assign char_ready = cnt_q <= CW'(DEPTH - MAX_RES);
	assign fire       = char_valid && char_ready;
	assign tok_valid  = cnt_q != '0;
	assign pop        = tok_valid && tok_ready;
	assign tok_item   = fifo_q[rptr_q];

	clx_core #(.LINE_WIDTH(LINE_WIDTH)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (char_item),
		.res       (res),
		.res_count (res_count)
	);

	// queue storage
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (fire && 3'(i) < res_count)
				fifo_q[wptr_q + PW'(i)] <= res[i];
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (fire) wptr_q <= wptr_q + PW'(res_count);
			if (pop) rptr_q <= rptr_q + PW'(1);
			cnt_q <= cnt_q + (fire ? CW'(res_count) : CW'(0)) - (pop ? CW'(1) : CW'(0));
		end
	end

endmodule

`default_nettype wire

// ===== rtl/clx_checker.sv =====
// port-level checks for the lexer top level, bound to it below
// depends on clx_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module clx_checker
	import clx_pkg::*;
(
	input wire logic  clk,
	input wire logic  arst_n,
	input wire logic  tok_valid,
	input wire logic  tok_ready,
	input wire token_item_t tok_item
);

	// a stalled token byte stays offered
	`ASSERT_NEXT(a_tok_hold, clk, arst_n, tok_valid && !tok_ready, tok_valid)

	// a stalled token byte keeps its payload
	`ASSERT_NEXT(a_tok_stable, clk, arst_n, tok_valid && !tok_ready, $stable(tok_item))

	// an empty literal is a lone final byte with zero text
	`ASSERT_IMPLY(a_empty_tok, clk, arst_n, tok_valid && !tok_item.value_valid,
		tok_item.value_byte == 8'd0 && tok_item.last_of_token)

	// only operators carry an operator code
	`ASSERT_IMPLY(a_code_class, clk, arst_n, tok_valid && tok_item.token_class != C_OP,
		tok_item.operator_code == OP_NONE)

endmodule

bind c_like_lexer_unit clx_checker u_clx_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.tok_valid (tok_valid),
	.tok_ready (tok_ready),
	.tok_item  (tok_item)
);

`default_nettype wire

// ===== sim/c_like_lexer_unit_test.sv =====
// testbench for c_like_lexer_unit: directed token table, then random source text
// checked against a token predictor; depends on clx_pkg and c_like_lexer_unit
`default_nettype none

module c_like_lexer_unit_test;
	import clx_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// lexer modes of the predictor
	typedef enum int {
		LX_IDLE, LX_IDENT, LX_STRING, LX_ZERO, LX_DECIMAL, LX_HEX,
		LX_OP1, LX_OP2, LX_LCOMMENT, LX_BLOCK, LX_BLOCK_STAR
	} lex_mode_t;

	// one directed row: source byte, end flag, optional typed token byte
	typedef struct {
		logic [7:0]  ch;
		logic        eot;
		logic        has_tok;
		token_item_t tok;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic char_valid = 1'b0;
	logic char_ready;
	char_item_t char_item = '0;
	logic tok_valid;
	logic tok_ready = 1'b0;
	token_item_t tok_item;

	int errors = 0;
	token_item_t pending_tokens[$];

	// predictor state
	lex_mode_t mode = LX_IDLE;
	logic [7:0] held_byte = 8'd0;
	int held_count = 0;
	logic [15:0] cur_line = 16'd1;
	logic [15:0] tok_line = 16'd1;

	c_like_lexer_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.char_valid(char_valid), .char_ready(char_ready), .char_item(char_item),
		.tok_valid(tok_valid), .tok_ready(tok_ready), .tok_item(tok_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("** c_like_lexer_unit: FAILED **");
		$finish;
	end

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// token byte expectation
	function automatic void push_tok(input logic [2:0] cls, input logic [5:0] code,
		input logic [7:0] b, input logic vld, input logic last);
		token_item_t t;
		t.token_class = cls;
		t.operator_code = code;
		t.value_byte = vld ? b : 8'd0;
		t.value_valid = vld;
		t.line_number = tok_line;
		t.last_of_token = last;
		pending_tokens.insert(pending_tokens.size(), t);
	endfunction

	function automatic void bump_line();
		if (cur_line != 16'hffff) cur_line++;
	endfunction

	function automatic void close_token();
		logic [5:0] code;
		case (mode)
			LX_IDENT: push_tok(C_IDENT, OP_NONE, held_byte, 1'b1, 1'b1);
			LX_DECIMAL, LX_ZERO: push_tok(C_DEC, OP_NONE, held_byte, 1'b1, 1'b1);
			LX_STRING: push_tok(C_STRING, OP_NONE, held_byte, held_count != 0, 1'b1);
			LX_HEX: push_tok(C_HEX, OP_NONE, held_byte, held_count != 0, 1'b1);
			LX_OP1: push_tok(C_OP, single_code(held_byte), held_byte, 1'b1, 1'b1);
			LX_OP2: begin
				code = (held_byte == CH_GT) ? OP_SHR : OP_SHL;
				push_tok(C_OP, code, held_byte, 1'b1, 1'b0);
				push_tok(C_OP, code, held_byte, 1'b1, 1'b1);
			end
			default: ;
		endcase
		mode = LX_IDLE;
		held_count = 0;
	endfunction

	function automatic void hold_byte(input lex_mode_t m, input logic [7:0] b, input int cnt);
		mode = m;
		held_byte = b;
		held_count = cnt;
		tok_line = cur_line;
	endfunction

	function automatic void take_next(input logic [2:0] cls, input logic [7:0] b);
		if (held_count != 0) push_tok(cls, OP_NONE, held_byte, 1'b1, 1'b0);
		held_byte = b;
		held_count = 1;
	endfunction

	// works out the token bytes that one source byte causes
	function automatic void lex_byte(input logic [7:0] b, input logic eot);
		logic [7:0] a;
		logic [5:0] code;
		a = held_byte;
		if (eot) begin
			close_token();
			cur_line = 16'd1;
			return;
		end
		case (mode)
			LX_IDENT: if (is_word(b)) begin take_next(C_IDENT, b); return; end
			LX_DECIMAL: if (is_digit(b)) begin take_next(C_DEC, b); return; end
			LX_ZERO: begin
				if (b == CH_X) begin mode = LX_HEX; held_count = 0; return; end
				if (is_digit(b)) begin mode = LX_DECIMAL; take_next(C_DEC, b); return; end
			end
			LX_HEX: if (is_xdigit(b)) begin take_next(C_HEX, b); return; end
			LX_STRING: begin
				if (b == CH_QUOTE) begin close_token(); return; end
				if (b == CH_NL) bump_line();
				take_next(C_STRING, b);
				return;
			end
			LX_OP1: begin
				if (a == CH_SLASH && b == CH_SLASH) begin
					mode = LX_LCOMMENT; held_count = 0; return;
				end
				if (a == CH_SLASH && b == CH_STAR) begin
					mode = LX_BLOCK; held_count = 0; return;
				end
				if ((a == CH_GT || a == CH_LT) && b == a) begin
					mode = LX_OP2; held_count = 2; return;
				end
				code = pair_code(a, b);
				if (code != OP_NONE) begin
					push_tok(C_OP, code, a, 1'b1, 1'b0);
					push_tok(C_OP, code, b, 1'b1, 1'b1);
					mode = LX_IDLE; held_count = 0;
					return;
				end
			end
			LX_OP2: if (b == CH_EQ) begin
				code = (a == CH_GT) ? OP_SHREQ : OP_SHLEQ;
				push_tok(C_OP, code, a, 1'b1, 1'b0);
				push_tok(C_OP, code, a, 1'b1, 1'b0);
				push_tok(C_OP, code, b, 1'b1, 1'b1);
				mode = LX_IDLE; held_count = 0;
				return;
			end
			LX_LCOMMENT: begin
				if (b == CH_NL) begin bump_line(); mode = LX_IDLE; end
				return;
			end
			LX_BLOCK, LX_BLOCK_STAR: begin
				if (b == CH_NL) begin bump_line(); mode = LX_BLOCK; end
				else if (mode == LX_BLOCK_STAR && b == CH_SLASH) mode = LX_IDLE;
				else mode = (b == CH_STAR) ? LX_BLOCK_STAR : LX_BLOCK;
				return;
			end
			default: mode = LX_IDLE;
		endcase
		close_token();
		// start of a new token
		if (b == CH_NL) bump_line();
		else if (is_blank(b)) ;
		else if (is_alpha(b) || b == CH_UNDER) hold_byte(LX_IDENT, b, 1);
		else if (b == CH_QUOTE) hold_byte(LX_STRING, 8'd0, 0);
		else if (b == CH_ZERO) hold_byte(LX_ZERO, b, 1);
		else if (is_digit(b)) hold_byte(LX_DECIMAL, b, 1);
		else if (starts_pair(b)) hold_byte(LX_OP1, b, 1);
		else begin
			tok_line = cur_line;
			push_tok(C_OP, single_code(b), b, 1'b1, 1'b1);
		end
	endfunction

	// receiver: stall pattern of its own, compare each transfer
	int stall_phase = 0;
	always @(posedge clk) begin
		token_item_t want;
		if (arst_n) begin
			if (tok_valid && tok_ready) begin
				if (pending_tokens.size() == 0) report("token byte with nothing expected");
				else begin
					want = pending_tokens.pop_front();
					if (tok_item.token_class !== want.token_class)
						report($sformatf("class %0d want %0d", tok_item.token_class,
							want.token_class));
					if (tok_item.operator_code !== want.operator_code)
						report($sformatf("op code %0d want %0d", tok_item.operator_code,
							want.operator_code));
					if (tok_item.value_byte !== want.value_byte)
						report($sformatf("byte %h want %h", tok_item.value_byte,
							want.value_byte));
					if (tok_item.value_valid !== want.value_valid)
						report("value valid differs");
					if (tok_item.line_number !== want.line_number)
						report($sformatf("line %0d want %0d", tok_item.line_number,
							want.line_number));
					if (tok_item.last_of_token !== want.last_of_token)
						report("last mark differs");
				end
			end
			stall_phase <= stall_phase + 1;
			if (stall_phase % 600 < 150) tok_ready <= 1'b1;
			else tok_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	int gap_left = 0;
	int burst_left = 0;

	// one source byte transfer, bursts with random gaps
	task automatic send_byte(input logic [7:0] b, input logic eot);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap_left > 0) char_valid <= 1'b0;
		end
		while (gap_left > 0) begin
			@(posedge clk);
			gap_left--;
		end
		char_valid <= 1'b1;
		char_item <= '{char_byte: b, end_of_text: eot};
		do @(posedge clk); while (!char_ready);
		lex_byte(b, eot);
		burst_left--;
	endtask

	function automatic logic [7:0] rand_char();
		int k;
		string pool;
		pool = "abzAZ_09x7f\"/*+-=<>&|.:!%^~,;#()[]{} \n\t";
		k = $urandom_range(0, 99);
		if (k < 80) return pool[$urandom_range(0, pool.len() - 1)];
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
	endtask

	dir_row_t rows[$];
	string frags[16] = '{"abc_1 ", "\"hi\\n\"", "0x1fZ ", "0x ", "12345;", "a>>=b",
		"x<<y", "<<=", "// c\n", "/* a */", "/*/ x */", "p->q", "a.*b", "::", "\"\"",
		"i++ += -- &&"};

	function automatic void add_row(input dir_row_t r);
		rows.insert(rows.size(), r);
	endfunction

	initial begin
		string s;
		int sent;
		// directed: extremes, empty literals, most operators, comments, end of text
		add_row('{8'h00, 1'b0, 1'b1, '{C_OP, OP_NONE, 8'h00, 1'b1, 16'd1, 1'b1}});
		add_row('{8'hff, 1'b0, 1'b1, '{C_OP, OP_NONE, 8'hff, 1'b1, 16'd1, 1'b1}});
		add_row('{"#", 1'b0, 1'b1, '{C_OP, OP_HASH, "#", 1'b1, 16'd1, 1'b1}});
		add_row('{"\"", 1'b0, 1'b0, '0});
		add_row('{"\"", 1'b0, 1'b1, '{C_STRING, OP_NONE, 8'h00, 1'b0, 16'd1, 1'b1}});
		add_row('{"0", 1'b0, 1'b0, '0});
		add_row('{"x", 1'b0, 1'b0, '0});
		add_row('{8'h0a, 1'b0, 1'b1, '{C_HEX, OP_NONE, 8'h00, 1'b0, 16'd1, 1'b1}});
		add_row('{"/", 1'b0, 1'b0, '0});
		add_row('{"*", 1'b0, 1'b0, '0});
		add_row('{"/", 1'b0, 1'b0, '0});
		add_row('{"*", 1'b0, 1'b0, '0});
		add_row('{"/", 1'b0, 1'b0, '0});
		add_row('{"~", 1'b0, 1'b1, '{C_OP, OP_TILDE, "~", 1'b1, 16'd2, 1'b1}});
		add_row('{">", 1'b0, 1'b0, '0});
		add_row('{">", 1'b0, 1'b0, '0});
		add_row('{8'h00, 1'b1, 1'b0, '0});
		add_row('{"q", 1'b0, 1'b0, '0});
		add_row('{8'h55, 1'b1, 1'b1, '{C_IDENT, OP_NONE, "q", 1'b1, 16'd1, 1'b1}});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			send_byte(rows[i].ch, rows[i].eot);
			// a typed row names the last token byte its transfer causes
			if (rows[i].has_tok) begin
				if (pending_tokens.size() == 0 || pending_tokens[$] !== rows[i].tok)
					report($sformatf("directed row %0d differs from typed token", i));
			end
		end
		send_text("== = : + += - -= * *= /= / & &= | |= || ^= ^ >= > <= < %= % != !");
		send_text(" , . ( ) [ ] { } ; >>x <<=y ");
		send_byte(8'h00, 1'b1);

		// random: mostly well-formed fragments, some noise
		sent = 0;
		while (sent < 320) begin
			if ($urandom_range(0, 3) != 0) begin
				s = frags[$urandom_range(0, 15)];
				send_text(s);
				sent += s.len();
			end else begin
				send_byte(rand_char(), $urandom_range(0, 40) == 0);
				sent++;
			end
		end
		send_byte(8'h00, 1'b1);
		char_valid <= 1'b0;

		while (pending_tokens.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("** c_like_lexer_unit: PASSED **");
		else
			$display("** c_like_lexer_unit: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire

// ===== c_like_lexer_unit.f =====
+incdir+rtl
rtl/clx_pkg.sv
rtl/clx_core.sv
rtl/c_like_lexer_unit.sv
rtl/clx_checker.sv
sim/c_like_lexer_unit_test.sv
